>>> src/sdm_pkg.sv
// shared types and constants for the signed division magic number block
// no dependencies

package sdm_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned InWidth    = 32;
  localparam int unsigned OutWidth   = 32;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned IterWidth  = $clog2(WordWidth + 1);
  localparam int unsigned CntWidth   = $clog2(WordWidth);

  localparam logic [WordWidth-1:0] WordHalf = {1'b1, {(WordWidth-1){1'b0}}};
  localparam logic [WordWidth-1:0] WordOne  = WordWidth'(1);
  localparam logic [WordWidth-1:0] WordOnes = {WordWidth{1'b1}};

  typedef enum logic [2:0] {
    StIdle,
    StDiv2,
    StAnc,
    StInit1,
    StDiv1,
    StSeed,
    StLoop,
    StFinish
  } sdm_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic set_anc;
    logic init1;
    logic seed;
    logic loop_step;
    logic finish;
  } sdm_cmd_t;

  typedef struct packed {
    logic bad;
    logic stop;
    logic it_zero;
    logic it_full;
  } sdm_status_t;

endpackage

>>> src/sdm_datapath.sv
// datapath: shared restoring divider, nc computation, doubling loop and result register
// depends on sdm_pkg

module sdm_datapath (
  input  logic                         clk_i,
  input  sdm_pkg::sdm_cmd_t            cmd_i,
  output sdm_pkg::sdm_status_t         status_o,
  input  logic [sdm_pkg::InWidth-1:0]  divisor_i,
  output logic [sdm_pkg::OutWidth-1:0] magic_multiplier_o,
  output logic [sdm_pkg::ShiftWidth-1:0] post_shift_o,
  output logic                         status_bit_o,
  output logic                         power_of_two_o
);
  import sdm_pkg::*;

  logic [WordWidth-1:0] ad_q, ad_d;
  logic                 neg_q, neg_d;
  logic                 bad_q, bad_d;
  logic                 pow_q, pow_d;
  logic [WordWidth-1:0] rem_q, rem_d;
  logic [WordWidth-1:0] dq_q, dq_d;
  logic [WordWidth-1:0] dsr_q, dsr_d;
  logic [WordWidth-1:0] anc_q, anc_d;
  logic [WordWidth-1:0] q1_q, q1_d, r1_q, r1_d;
  logic [WordWidth-1:0] q2_q, q2_d, r2_q, r2_d;
  logic [IterWidth-1:0] it_q, it_d;
  logic [OutWidth-1:0]  mult_out_q, mult_out_d;
  logic [ShiftWidth-1:0] shift_out_q, shift_out_d;
  logic                 stat_out_q, stat_out_d;
  logic                 pow_out_q, pow_out_d;

  logic [WordWidth-1:0] in_u, in_ad;
  logic                 in_neg;
  logic [WordWidth:0]   cand, diff;
  logic                 cand_ge;
  logic [WordWidth-1:0] rem_p1, tmod, anc_raw;
  logic [WordWidth-1:0] r1s, r2s, delta, mult, mult_sgn;
  logic                 r1_ge, r2_ge;
  logic [IterWidth-1:0] it_m1;

  always_comb begin
    in_u   = divisor_i[WordWidth-1:0];
    in_neg = in_u[WordWidth-1];
    in_ad  = in_neg ? (WordWidth'(0) - in_u) : in_u;

    // one restoring step
    cand    = {rem_q, dq_q[WordWidth-1]};
    diff    = cand - {1'b0, dsr_q};
    cand_ge = (cand >= {1'b0, dsr_q});

    // remainder of 2^(w-1)+neg by |d| from that of 2^(w-1)
    rem_p1  = rem_q + WordOne;
    if (neg_q) begin
      tmod = (rem_p1 == ad_q) ? '0 : rem_p1;
    end else begin
      tmod = rem_q;
    end
    anc_raw = WordHalf + WordWidth'(neg_q) - WordOne - tmod;

    r1s   = {r1_q[WordWidth-2:0], 1'b0};
    r2s   = {r2_q[WordWidth-2:0], 1'b0};
    r1_ge = (r1s >= anc_q);
    r2_ge = (r2s >= ad_q);
    delta = ad_q - r2_q;

    mult     = q2_q + WordOne;
    mult_sgn = neg_q ? (WordWidth'(0) - mult) : mult;
    it_m1    = it_q - IterWidth'(1);

    ad_d  = ad_q;
    neg_d = neg_q;
    bad_d = bad_q;
    pow_d = pow_q;
    rem_d = rem_q;
    dq_d  = dq_q;
    dsr_d = dsr_q;
    anc_d = anc_q;
    q1_d  = q1_q;
    r1_d  = r1_q;
    q2_d  = q2_q;
    r2_d  = r2_q;
    it_d  = it_q;
    mult_out_d  = mult_out_q;
    shift_out_d = shift_out_q;
    stat_out_d  = stat_out_q;
    pow_out_d   = pow_out_q;

    if (cmd_i.load) begin
      ad_d  = in_ad;
      neg_d = in_neg;
      bad_d = (in_u == '0) || (in_u == WordOne) || (in_u == WordOnes);
      pow_d = ((in_ad & (in_ad - WordOne)) == '0);
      rem_d = '0;
      dq_d  = WordHalf;
      dsr_d = in_ad;
    end
    if (cmd_i.div_step) begin
      rem_d = cand_ge ? diff[WordWidth-1:0] : cand[WordWidth-1:0];
      dq_d  = {dq_q[WordWidth-2:0], cand_ge};
    end
    if (cmd_i.set_anc) begin
      q2_d  = dq_q;
      r2_d  = rem_q;
      anc_d = (anc_raw == '0) ? WordOne : anc_raw;
    end
    if (cmd_i.init1) begin
      rem_d = '0;
      dq_d  = WordHalf;
      dsr_d = anc_q;
    end
    if (cmd_i.seed) begin
      q1_d = dq_q;
      r1_d = rem_q;
      it_d = '0;
    end
    if (cmd_i.loop_step) begin
      q1_d = {q1_q[WordWidth-2:0], 1'b0} + WordWidth'(r1_ge);
      r1_d = r1_ge ? (r1s - anc_q) : r1s;
      q2_d = {q2_q[WordWidth-2:0], 1'b0} + WordWidth'(r2_ge);
      r2_d = r2_ge ? (r2s - ad_q) : r2s;
      it_d = it_q + IterWidth'(1);
    end
    if (cmd_i.finish) begin
      mult_out_d  = bad_q ? '0 : OutWidth'(mult_sgn);
      shift_out_d = bad_q ? '0 : ShiftWidth'(it_m1);
      stat_out_d  = bad_q;
      pow_out_d   = pow_q & ~bad_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q  <= ad_d;
    neg_q <= neg_d;
    bad_q <= bad_d;
    pow_q <= pow_d;
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dsr_q <= dsr_d;
    anc_q <= anc_d;
    q1_q  <= q1_d;
    r1_q  <= r1_d;
    q2_q  <= q2_d;
    r2_q  <= r2_d;
    it_q  <= it_d;
    mult_out_q  <= mult_out_d;
    shift_out_q <= shift_out_d;
    stat_out_q  <= stat_out_d;
    pow_out_q   <= pow_out_d;
  end

  assign status_o.bad     = bad_q;
  assign status_o.stop    = ~((q1_q < delta) || ((q1_q == delta) && (r1_q == '0)));
  assign status_o.it_zero = (it_q == '0);
  assign status_o.it_full = (it_q == IterWidth'(WordWidth));

  assign magic_multiplier_o = mult_out_q;
  assign post_shift_o       = shift_out_q;
  assign status_bit_o       = stat_out_q;
  assign power_of_two_o     = pow_out_q;

endmodule

>>> src/sdm_ctrl.sv
// controller: sequences the two divisions, the doubling loop and the output transfer
// depends on sdm_pkg

module sdm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sdm_pkg::sdm_status_t status_i,
  output sdm_pkg::sdm_cmd_t    cmd_o
);
  import sdm_pkg::*;

  sdm_state_e          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                cnt_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cnt_last    = (cnt_q == CntWidth'(WordWidth - 1));

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StDiv2;
        end
      end
      StDiv2: begin
        if (status_i.bad) begin
          state_d = StFinish;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + CntWidth'(1);
          if (cnt_last) begin
            state_d = StAnc;
          end
        end
      end
      StAnc: begin
        cmd_o.set_anc = 1'b1;
        state_d       = StInit1;
      end
      StInit1: begin
        cmd_o.init1 = 1'b1;
        cnt_d       = '0;
        state_d     = StDiv1;
      end
      StDiv1: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntWidth'(1);
        if (cnt_last) begin
          state_d = StSeed;
        end
      end
      StSeed: begin
        cmd_o.seed = 1'b1;
        state_d    = StLoop;
      end
      StLoop: begin
        if ((!status_i.it_zero && status_i.stop) || status_i.it_full) begin
          state_d = StFinish;
        end else begin
          cmd_o.loop_step = 1'b1;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/signed_division_magic_number.sv
// top level of the signed division magic number block
// depends on sdm_pkg, sdm_ctrl and sdm_datapath
//
// channel  direction  handshake               payload
// in       input      in_valid_i/in_ready_o   divisor_i
// out      output     out_valid_o/out_ready_i magic_multiplier_o, post_shift_o,
//                                             status_o, power_of_two_o
//
// one item at a time: a load, two serial divisions on the shared restoring
// divider, the set-up states StAnc, StInit1 and StSeed, 1 to 32 doubling
// iterations and a final write of the result register; bad divisors go from
// StDiv2 straight to StFinish
// reset is asynchronous, active low, and clears the controller only
// a new divisor is taken while the previous result waits in the output
// register; the block stalls before writing a result until that register is free

module signed_division_magic_number (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sdm_pkg::InWidth-1:0]    divisor_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sdm_pkg::OutWidth-1:0]   magic_multiplier_o,
  output logic [sdm_pkg::ShiftWidth-1:0] post_shift_o,
  output logic                           status_o,
  output logic                           power_of_two_o
);
  import sdm_pkg::*;

  sdm_cmd_t    cmd;
  sdm_status_t status;

  sdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sdm_datapath u_datapath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .divisor_i          (divisor_i),
    .magic_multiplier_o (magic_multiplier_o),
    .post_shift_o       (post_shift_o),
    .status_bit_o       (status_o),
    .power_of_two_o     (power_of_two_o)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for signed_division_magic_number: divisors are streamed
// in, and every result is checked against predicted values of all four outputs
// depends on sdm_pkg and signed_division_magic_number

module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned TailCycles = 150;
  localparam logic [63:0] HalfWord = 64'h8000_0000;
  localparam logic [63:0] WordMask = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [sdm_pkg::InWidth-1:0]    divisor;
    logic [sdm_pkg::OutWidth-1:0]   multiplier;
    logic [sdm_pkg::ShiftWidth-1:0] shift;
    logic                           bad;
    logic                           pow2;
  } magic_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [sdm_pkg::InWidth-1:0]    divisor = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [sdm_pkg::OutWidth-1:0]   magic_multiplier;
  logic [sdm_pkg::ShiftWidth-1:0] post_shift;
  logic                           status;
  logic                           power_of_two;

  logic [sdm_pkg::InWidth-1:0] divisor_pending[$];
  magic_t                      magic_expected[$];
  int unsigned                 mismatches = 0;
  int unsigned                 results_checked = 0;
  int unsigned                 divisors_sent = 0;
  int unsigned                 bad_seen = 0;
  int unsigned                 pow2_seen = 0;
  int unsigned                 cycles = 0;
  int unsigned                 send_gap = 0;
  int unsigned                 stall_left = 0;
  logic                        draining = 1'b0;

  signed_division_magic_number dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .divisor_i          (divisor),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .magic_multiplier_o (magic_multiplier),
    .post_shift_o       (post_shift),
    .status_o           (status),
    .power_of_two_o     (power_of_two)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic magic_t compute_magic(input logic [31:0] d);
    magic_t      r;
    logic [31:0] abs32;
    logic [31:0] mult;
    logic [63:0] ad, t, anc, q1, r1, q2, r2, delta;
    logic        neg;
    logic        settled;
    int          p;
    r = '0;
    r.divisor = d;
    neg = d[31];
    p = 31;
    if (d == 32'd0 || d == 32'd1 || d == 32'hFFFF_FFFF) begin
      r.bad = 1'b1;
      return r;
    end
    abs32 = neg ? -d : d;
    ad = 64'(abs32);
    t = HalfWord + 64'(neg);
    anc = (t - 64'd1 - (t % ad)) & WordMask;
    if (anc == 64'd0) anc = 64'd1;
    q1 = HalfWord / anc;
    r1 = (HalfWord - q1 * anc) & WordMask;
    q2 = HalfWord / ad;
    r2 = (HalfWord - q2 * ad) & WordMask;
    settled = 1'b0;
    for (int i = 0; i < 32 && !settled; i++) begin
      p++;
      q1 = (q1 << 1) & WordMask;
      r1 = (r1 << 1) & WordMask;
      if (r1 >= anc) begin
        q1 = (q1 + 64'd1) & WordMask;
        r1 = (r1 - anc) & WordMask;
      end
      q2 = (q2 << 1) & WordMask;
      r2 = (r2 << 1) & WordMask;
      if (r2 >= ad) begin
        q2 = (q2 + 64'd1) & WordMask;
        r2 = (r2 - ad) & WordMask;
      end
      delta = (ad - r2) & WordMask;
      if (!(q1 < delta || (q1 == delta && r1 == 64'd0))) settled = 1'b1;
    end
    mult = 32'(q2 + 64'd1);
    if (neg) mult = -mult;
    r.multiplier = mult;
    r.shift = 5'(p - 32);
    r.pow2 = ((ad & (ad - 64'd1)) == 64'd0);
    return r;
  endfunction

  // mostly back-to-back, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [31:0] random_divisor();
    int unsigned roll;
    int unsigned k;
    logic [31:0] v;
    roll = $urandom_range(0, 99);
    k = $urandom_range(1, 31);
    if (roll < 25) begin
      v = $urandom;
    end else if (roll < 50) begin
      v = 32'($signed($urandom_range(0, 2000)) - 1000);
    end else if (roll < 65) begin
      v = $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 1)) v = -v;
    end else if (roll < 80) begin
      v = 32'd1 << k;
      if ($urandom_range(0, 1)) v = -v;
    end else if (roll < 95) begin
      v = (32'd1 << k) + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = 32'($signed($urandom_range(0, 2)) - 1);
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want, input logic [31:0] d);
    $display("mismatch %s: divisor %h got %h expected %h", what, d, got, want);
    mismatches++;
  endtask

  // input side: one transfer per accepted divisor, prediction taken on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        magic_expected.push_back(compute_magic(divisor));
        divisors_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (divisor_pending.size() > 0) begin
          in_valid <= 1'b1;
          divisor <= divisor_pending.pop_front();
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: random back-pressure, field by field comparison
  always @(posedge clk_i or negedge rst_ni) begin
    magic_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (magic_expected.size() == 0) begin
          report_mismatch("unexpected result", magic_multiplier, '0, '0);
        end else begin
          want = magic_expected.pop_front();
          results_checked++;
          if (want.bad) bad_seen++;
          if (want.pow2) pow2_seen++;
          if (magic_multiplier !== want.multiplier)
            report_mismatch("multiplier", magic_multiplier, want.multiplier, want.divisor);
          if (post_shift !== want.shift)
            report_mismatch("post shift", 32'(post_shift), 32'(want.shift), want.divisor);
          if (status !== want.bad)
            report_mismatch("status", 32'(status), 32'(want.bad), want.divisor);
          if (power_of_two !== want.pow2)
            report_mismatch("power of two", 32'(power_of_two), 32'(want.pow2), want.divisor);
        end
      end
      if (draining) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("signed_division_magic_number regression: fail");
      $finish;
    end
  end

  initial begin
    // bad divisors, smallest magnitudes, extremes and bit patterns
    divisor_pending.push_back(32'd0);
    divisor_pending.push_back(32'd1);
    divisor_pending.push_back(32'hFFFF_FFFF);
    divisor_pending.push_back(32'd2);
    divisor_pending.push_back(32'hFFFF_FFFE);
    divisor_pending.push_back(32'd3);
    divisor_pending.push_back(32'hFFFF_FFFD);
    divisor_pending.push_back(32'd5);
    divisor_pending.push_back(32'hFFFF_FFFB);
    divisor_pending.push_back(32'd6);
    divisor_pending.push_back(32'd7);
    divisor_pending.push_back(32'hFFFF_FFF9);
    divisor_pending.push_back(32'd25);
    divisor_pending.push_back(32'd125);
    divisor_pending.push_back(32'd641);
    divisor_pending.push_back(32'h7FFF_FFFF);
    divisor_pending.push_back(32'h7FFF_FFFE);
    divisor_pending.push_back(32'h8000_0000);
    divisor_pending.push_back(32'h8000_0001);
    divisor_pending.push_back(32'h4000_0000);
    divisor_pending.push_back(32'hC000_0000);
    divisor_pending.push_back(32'h5555_5555);
    divisor_pending.push_back(32'hAAAA_AAAA);
    for (int n = 0; n < RandomItems; n++) divisor_pending.push_back(random_divisor());

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (divisor_pending.size() != 0 || in_valid) @(posedge clk_i);
    while (magic_expected.size() != 0) @(posedge clk_i);
    draining = 1'b1;
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d divisors sent, %0d results checked, %0d mismatches", divisors_sent,
             results_checked, mismatches);
    $display("covered %0d bad divisors and %0d power-of-two divisors", bad_seen, pow2_seen);
    if (mismatches == 0 && magic_expected.size() == 0) begin
      $display("signed_division_magic_number regression: pass");
    end else begin
      $display("signed_division_magic_number regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sdm_pkg.sv
src/sdm_datapath.sv
src/sdm_ctrl.sv
src/signed_division_magic_number.sv
dv/testbench.sv
